// ----- rtl/scs_pkg.sv -----
// Shared types and character constants for the source comment stripper.
package scs_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_STAR   = 3'd4
  } mode_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_end;
    logic       unterminated_comment;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } pair_t;

  typedef struct packed {
    logic  push;
    pair_t pair;
    mode_t mode_next;
    logic  pws_next;
  } dec_t;

endpackage

// ----- rtl/scs_decode.sv -----
// Per-byte decode: next scan state and up to two results for one character.
module scs_decode import scs_pkg::*; (
  input  logic [7:0] ch,
  input  mode_t      mode,
  input  logic       prev_was_space,
  output dec_t       dec
);

  typedef struct packed {
    logic  emit;
    res_t  res;
    mode_t mode;
    logic  pws;
  } nb_t;

  function automatic nb_t normal_byte(input logic [7:0] c, input logic pws);
    nb_t r;
    r.emit = 1'b0;
    r.res  = '{out_char: c, is_end: 1'b0, unterminated_comment: 1'b0};
    r.mode = MODE_NORMAL;
    r.pws  = 1'b0;
    priority if (c == CH_NUL) begin
      r.emit = 1'b1;
      r.res.is_end = 1'b1;
    end else if (c == CH_SLASH) begin
      r.mode = MODE_SLASH;
    end else if (c == CH_HASH) begin
      r.mode = MODE_LINE;
    end else if (c == CH_SPACE) begin
      r.emit = !pws;
      r.pws  = 1'b1;
    end else if (c == CH_LF || c == CH_TAB || c == CH_CR) begin
      r.emit = 1'b0;
    end else begin
      r.emit = 1'b1;
    end
    return r;
  endfunction

  nb_t nb;
  res_t slash_res;
  res_t end_res;

  assign nb        = normal_byte(ch, prev_was_space);
  assign slash_res = '{out_char: CH_SLASH, is_end: 1'b0, unterminated_comment: 1'b0};
  assign end_res   = '{out_char: CH_NUL, is_end: 1'b1, unterminated_comment: 1'b0};

  always_comb begin
    dec.push      = 1'b0;
    dec.pair.two  = 1'b0;
    dec.pair.r0   = nb.res;
    dec.pair.r1   = nb.res;
    dec.mode_next = mode;
    dec.pws_next  = prev_was_space;
    unique case (mode)
      MODE_SLASH: begin
        priority if (ch == CH_SLASH) begin
          dec.mode_next = MODE_LINE;
        end else if (ch == CH_STAR) begin
          dec.mode_next = MODE_BLOCK;
        end else begin
          dec.push      = 1'b1;
          dec.pair.r0   = slash_res;
          dec.pair.two  = nb.emit;
          dec.mode_next = nb.mode;
          dec.pws_next  = nb.pws;
        end
      end
      MODE_LINE: begin
        dec.pws_next = 1'b0;
        priority if (ch == CH_NUL) begin
          dec.push      = 1'b1;
          dec.pair.r0   = end_res;
          dec.mode_next = MODE_NORMAL;
        end else if (ch == CH_LF) begin
          dec.mode_next = MODE_NORMAL;
        end else begin
          dec.mode_next = MODE_LINE;
        end
      end
      MODE_BLOCK, MODE_STAR: begin
        dec.pws_next = 1'b0;
        priority if (ch == CH_NUL) begin
          dec.push      = 1'b1;
          dec.pair.r0   = end_res;
          dec.pair.r0.unterminated_comment = 1'b1;
          dec.mode_next = MODE_NORMAL;
        end else if (ch == CH_STAR) begin
          dec.mode_next = MODE_STAR;
        end else if (ch == CH_SLASH && mode == MODE_STAR) begin
          dec.mode_next = MODE_NORMAL;
        end else begin
          dec.mode_next = MODE_BLOCK;
        end
      end
      default: begin
        dec.push      = nb.emit;
        dec.mode_next = nb.mode;
        dec.pws_next  = nb.pws;
      end
    endcase
  end

endmodule

// ----- rtl/scs_pair_fifo.sv -----
// Two-entry queue of one or two results per entry, drained one per cycle while ready.
module scs_pair_fifo import scs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pair_t      pair,
  output logic       full,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic [1:0] m_axis_tuser,   // [0] is_end, [1] unterminated_comment
  output logic       m_axis_tlast    // last_of_run
);

  pair_t       mem [2];
  logic [1:0]  cnt;
  logic        head;
  logic        tail;
  logic        sub;
  logic [1:0]  cnt_next;
  logic        pop_item;
  logic        pair_last;
  logic        pair_pop;
  res_t        cur;

  assign m_axis_tvalid = (cnt != 2'd0);
  assign pop_item      = m_axis_tvalid && m_axis_tready;
  assign pair_last     = sub || !mem[head].two;
  assign pair_pop      = pop_item && pair_last;
  assign full          = cnt[1];
  assign cur           = sub ? mem[head].r1 : mem[head].r0;
  assign m_axis_tdata  = cur.out_char;
  assign m_axis_tuser  = {cur.unterminated_comment, cur.is_end};
  assign m_axis_tlast  = pair_last;

  always_comb begin
    cnt_next = cnt;
    unique case ({push, pair_pop})
      2'b10:   cnt_next = cnt + 2'd1;
      2'b01:   cnt_next = cnt - 2'd1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= 2'd0;
      head <= 1'b0;
      tail <= 1'b0;
      sub  <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        tail <= ~tail;
      end
      if (pair_pop) begin
        head <= ~head;
      end
      if (pop_item) begin
        sub <= !pair_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= pair;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pair_pop)
    else $error("push into full result queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("result queue count out of range");

  a_sub_two: assert property (@(posedge clk) disable iff (rst)
    sub |-> m_axis_tvalid && mem[head].two)
    else $error("second result selected on single-result entry");

endmodule

// ----- rtl/source_comment_stripper_core.sv -----
// Streaming stripper of C line and block comments and '#' lines: one source
// byte in, up to two kept bytes out. An accepted byte is held in the input
// register, decoded, and its results written to the result queue. One byte
// per cycle while the queue has room; a held '/' leaves with the next byte.
// Synchronous active-high reset returns the scanner to normal text and
// empties the input register and the two-entry result queue.
module source_comment_stripper_core import scs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic [1:0] m_axis_tuser,   // [0] is_end, [1] unterminated_comment
  output logic       m_axis_tlast    // last_of_run
);

  logic       in_valid;
  logic [7:0] in_ch;
  mode_t      mode;
  logic       prev_was_space;
  dec_t       dec;
  logic       full;
  logic       consume;
  logic       s_accept;

  scs_decode u_decode (
    .ch             (in_ch),
    .mode           (mode),
    .prev_was_space (prev_was_space),
    .dec            (dec)
  );

  assign consume       = in_valid && (!dec.push || !full);
  assign s_axis_tready = !in_valid || consume;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      mode           <= MODE_NORMAL;
      prev_was_space <= 1'b0;
    end else begin
      if (s_accept) begin
        in_valid <= 1'b1;
      end else if (consume) begin
        in_valid <= 1'b0;
      end
      if (consume) begin
        mode           <= dec.mode_next;
        prev_was_space <= dec.pws_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_ch <= s_axis_tdata;
    end
  end

  scs_pair_fifo u_fifo (
    .clk           (clk),
    .rst           (rst),
    .push          (consume && dec.push),
    .pair          (dec.pair),
    .full          (full),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    consume && in_ch == CH_NUL |=> mode == MODE_NORMAL && !prev_was_space)
    else $error("scanner state not cleared after terminator");

  a_err_on_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] && m_axis_tlast)
    else $error("unterminated flag on a non-end result");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == CH_NUL)
    else $error("end result not last of its request");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the streaming source comment stripper core.
module tb_top;
  import scs_pkg::*;

  localparam int N_RANDOM   = 850;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 64;

  class strip_scoreboard;
    typedef struct packed {
      logic [7:0] ch;
      logic       is_end;
      logic       unterm;
      logic       last;
    } kept_t;

    kept_t kept_q[$];
    kept_t step_q[$];
    mode_t mode;
    logic  prev_space;
    int    errors;

    function new();
      mode = MODE_NORMAL;
      prev_space = 1'b0;
      errors = 0;
    endfunction

    function void emit(logic [7:0] c, logic e, logic u);
      kept_t r;
      r.ch = c;
      r.is_end = e;
      r.unterm = u;
      r.last = 1'b0;
      step_q.push_back(r);
    endfunction

    function void close_text(logic u);
      emit(CH_NUL, 1'b1, u);
      mode = MODE_NORMAL;
      prev_space = 1'b0;
    endfunction

    function void plain_byte(logic [7:0] c);
      if (c == CH_NUL) begin
        close_text(1'b0);
      end else if (c == CH_SLASH) begin
        mode = MODE_SLASH;
        prev_space = 1'b0;
      end else if (c == CH_HASH) begin
        mode = MODE_LINE;
        prev_space = 1'b0;
      end else if (c == CH_SPACE) begin
        if (!prev_space) emit(c, 1'b0, 1'b0);
        prev_space = 1'b1;
      end else if (c == CH_LF || c == CH_TAB || c == CH_CR) begin
        prev_space = 1'b0;
      end else begin
        emit(c, 1'b0, 1'b0);
        prev_space = 1'b0;
      end
    endfunction

    function void note_input(logic [7:0] c);
      step_q.delete();
      case (mode)
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            mode = MODE_LINE;
          end else if (c == CH_STAR) begin
            mode = MODE_BLOCK;
          end else begin
            emit(CH_SLASH, 1'b0, 1'b0);
            mode = MODE_NORMAL;
            plain_byte(c);
          end
        end
        MODE_LINE: begin
          if (c == CH_NUL) close_text(1'b0);
          else if (c == CH_LF) mode = MODE_NORMAL;
          prev_space = 1'b0;
        end
        MODE_BLOCK, MODE_STAR: begin
          if (c == CH_NUL) close_text(1'b1);
          else if (c == CH_STAR) mode = MODE_STAR;
          else if (c == CH_SLASH && mode == MODE_STAR) mode = MODE_NORMAL;
          else mode = MODE_BLOCK;
          prev_space = 1'b0;
        end
        default: begin
          mode = MODE_NORMAL;
          plain_byte(c);
        end
      endcase
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) kept_q.push_back(step_q[i]);
    endfunction

    function void check_result(logic [7:0] d, logic [1:0] u, logic l);
      kept_t want;
      kept_t got;
      got.ch = d;
      got.is_end = u[0];
      got.unterm = u[1];
      got.last = l;
      if (kept_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result char=%02h end=%b unterm=%b last=%b",
                 $time, got.ch, got.is_end, got.unterm, got.last);
      end else begin
        want = kept_q.pop_front();
        if (want != got) begin
          errors++;
          $display("%0t: mismatch expected char=%02h end=%b unterm=%b last=%b, %s",
                   $time, want.ch, want.is_end, want.unterm, want.last, "actual");
          $display("%0t:          actual   char=%02h end=%b unterm=%b last=%b",
                   $time, got.ch, got.is_end, got.unterm, got.last);
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  strip_scoreboard sb;
  int   n_sent = 0;
  int   idle_cycles = 0;
  logic quiet = 1'b0;
  logic long_hold = 1'b0;

  source_comment_stripper_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // entered at a falling edge, returns at the falling edge after the request
  task send_byte(input logic [7:0] b);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_input(b);
    n_sent++;
    @(negedge clk);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst = 1'b0;
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] directed[$];
    logic [7:0] tok[$];
    int total;
    int len;
    logic held_once;
    logic paused_once;

    sb = new();
    held_once = 1'b0;
    paused_once = 1'b0;
    // extremes, space merge, held slash, line/block/hash drops, back-to-back
    // comments, spaces around a comment, slash before end, open block at end
    directed = '{8'hff, CH_SPACE, CH_SPACE, 8'h01, CH_SLASH, 8'h80,
                 CH_SLASH, CH_SLASH, 8'h63, CH_LF, CH_SPACE,
                 CH_SLASH, CH_STAR, CH_STAR, CH_SLASH,
                 CH_SLASH, CH_STAR, CH_STAR, CH_SLASH, CH_SPACE,
                 CH_HASH, CH_LF, CH_TAB, CH_CR, CH_SLASH, CH_NUL,
                 CH_SLASH, CH_STAR, CH_NUL};
    total = directed.size() + N_RANDOM;

    repeat (4) @(negedge clk);
    foreach (directed[i]) send_byte(directed[i]);

    while (n_sent < total) begin
      if (!held_once && n_sent >= 300) begin
        held_once = 1'b1;
        long_hold = 1'b1;
      end
      if (!paused_once && n_sent >= 500) begin
        paused_once = 1'b1;
        s_axis_tvalid = 1'b0;
        while (sb.kept_q.size() != 0) @(negedge clk);
      end
      if (n_sent >= total - 120) quiet = 1'b1;

      tok.delete();
      case ($urandom_range(0, 15))
        0, 1, 2, 3: begin
          len = $urandom_range(1, 6);
          repeat (len) tok.push_back(8'($urandom_range(8'h21, 8'h7e)));
        end
        4, 5: begin
          len = $urandom_range(1, 4);
          repeat (len) tok.push_back(($urandom_range(0, 3) == 0) ? CH_TAB : CH_SPACE);
        end
        6, 7: begin
          tok.push_back(CH_SLASH);
          tok.push_back(CH_SLASH);
          len = $urandom_range(0, 8);
          repeat (len) tok.push_back(8'($urandom_range(1, 255)));
          tok.push_back(CH_LF);
        end
        8, 9: begin
          tok.push_back(CH_SLASH);
          tok.push_back(CH_STAR);
          len = $urandom_range(0, 8);
          repeat (len) begin
            case ($urandom_range(0, 4))
              0: tok.push_back(CH_STAR);
              1: tok.push_back(CH_SLASH);
              2: tok.push_back(CH_SPACE);
              3: tok.push_back(CH_LF);
              default: tok.push_back(8'($urandom_range(1, 255)));
            endcase
          end
          tok.push_back(CH_STAR);
          tok.push_back(CH_SLASH);
        end
        10: begin
          tok.push_back(CH_HASH);
          len = $urandom_range(0, 6);
          repeat (len) tok.push_back(8'($urandom_range(1, 255)));
          tok.push_back(CH_LF);
        end
        11: begin
          case ($urandom_range(0, 2))
            0: tok.push_back(CH_LF);
            1: tok.push_back(CH_CR);
            default: tok.push_back(CH_TAB);
          endcase
        end
        12, 13: tok.push_back(8'($urandom_range(0, 255)));
        14: tok.push_back(CH_NUL);
        default: tok.push_back(8'($urandom_range(8'h80, 8'hff)));
      endcase
      foreach (tok[i]) send_byte(tok[i]);
    end

    s_axis_tvalid = 1'b0;
    while (sb.kept_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.kept_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- source_comment_stripper_core.f -----
rtl/scs_pkg.sv
rtl/scs_decode.sv
rtl/scs_pair_fifo.sv
rtl/source_comment_stripper_core.sv
tb/tb_top.sv
